// ----- hdl/fcsb_pkg.sv -----
// Shared types, codes and constants of the frustum culling block.
`default_nettype none

package fcsb_pkg;

    localparam int NUM_PLANES_DEF  = 6;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int FRAC_BITS       = 16;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SPHERE = 2'd1;
    localparam logic [1:0] OP_BOX    = 2'd2;

    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
    localparam logic [1:0] VERDICT_INSIDE    = 2'd1;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd2;
    localparam logic [1:0] VERDICT_VISIBLE   = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Control from the sequencer to the dot-product unit.
    typedef struct packed {
        logic       init;
        logic       accum;
        logic [1:0] axis;
    } fcsb_ctl_t;

    // Sign of the largest and smallest corner distance after the last axis.
    typedef struct packed {
        logic hi_neg;
        logic lo_neg;
    } fcsb_sts_t;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fcsb_plane_mem.sv -----
// Plane storage: one row per plane holding nx, ny, nz and offset, registered read.
`default_nettype none

module fcsb_plane_mem #(
    parameter int NUM_PLANES = fcsb_pkg::NUM_PLANES_DEF,
    parameter int CW         = fcsb_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [fcsb_pkg::idx_w(NUM_PLANES)-1:0]   wr_addr,
    input  wire logic [4*CW-1:0]                          wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [fcsb_pkg::idx_w(NUM_PLANES)-1:0]   rd_addr,
    output logic      [4*CW-1:0]                          rd_data
);

    logic [4*CW-1:0] rows [NUM_PLANES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rows[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= rows[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fcsb_dot_unit.sv -----
// Shared dot-product unit: two multipliers for all axes and max/min corner accumulators.
`default_nettype none

module fcsb_dot_unit #(
    parameter int CW = fcsb_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire fcsb_pkg::fcsb_ctl_t       ctl,
    input  wire logic        [4*CW-1:0]    row,
    input  wire logic signed [CW-1:0]      a_x,
    input  wire logic signed [CW-1:0]      a_y,
    input  wire logic signed [CW-1:0]      a_z,
    input  wire logic signed [CW-1:0]      b_x,
    input  wire logic signed [CW-1:0]      b_y,
    input  wire logic signed [CW-1:0]      b_z,
    input  wire logic signed [CW-1:0]      extra,
    output fcsb_pkg::fcsb_sts_t            sts
);

    localparam int PW = 2 * CW;
    localparam int AW = 2 * CW + 3;

    logic signed [CW-1:0] n_sel;
    logic signed [CW-1:0] a_sel;
    logic signed [CW-1:0] b_sel;
    logic signed [CW-1:0] w_val;
    logic signed [PW-1:0] prod_a_reg;
    logic signed [PW-1:0] prod_b_reg;
    logic signed [PW-1:0] big;
    logic signed [PW-1:0] sml;
    logic signed [AW-1:0] base;
    logic signed [AW-1:0] hi_sum;
    logic signed [AW-1:0] lo_sum;
    logic signed [AW-1:0] acc_hi_reg;
    logic signed [AW-1:0] acc_lo_reg;

    always_comb
    begin
        case (ctl.axis)
            fcsb_pkg::AXIS_X:
            begin
                n_sel = row[CW-1:0];
                a_sel = a_x;
                b_sel = b_x;
            end
            fcsb_pkg::AXIS_Y:
            begin
                n_sel = row[2*CW-1:CW];
                a_sel = a_y;
                b_sel = b_y;
            end
            fcsb_pkg::AXIS_Z:
            begin
                n_sel = row[3*CW-1:2*CW];
                a_sel = a_z;
                b_sel = b_z;
            end
            default:
            begin
                n_sel = row[CW-1:0];
                a_sel = a_x;
                b_sel = b_x;
            end
        endcase
    end

    assign w_val = row[4*CW-1:3*CW];

    always_ff @(posedge clk)
    begin
        prod_a_reg <= PW'(n_sel) * PW'(a_sel);
        prod_b_reg <= PW'(n_sel) * PW'(b_sel);
    end

    // The corner extremes split per axis: take the larger and smaller product.
    always_comb
    begin
        if (prod_a_reg > prod_b_reg)
        begin
            big = prod_a_reg;
            sml = prod_b_reg;
        end
        else
        begin
            big = prod_b_reg;
            sml = prod_a_reg;
        end
    end

    assign base   = (AW'(w_val) <<< fcsb_pkg::FRAC_BITS) + (AW'(extra) <<< fcsb_pkg::FRAC_BITS);
    assign hi_sum = acc_hi_reg + AW'(big);
    assign lo_sum = acc_lo_reg + AW'(sml);

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            acc_hi_reg <= base;
            acc_lo_reg <= base;
        end
        else if (ctl.accum)
        begin
            acc_hi_reg <= hi_sum;
            acc_lo_reg <= lo_sum;
        end
    end

    assign sts.hi_neg = hi_sum[AW-1];
    assign sts.lo_neg = lo_sum[AW-1];

endmodule

`default_nettype wire

// ----- hdl/frustum_cull_sphere_box.sv -----
// Frustum culling of spheres and boxes against a loaded plane set: sequencer and ports.
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_stall     op, plane_index, first_*, second_*
//  result    out        result_valid / result_stall verdict
//
// A load gives no result; op 3 is accepted and dropped.
// A test runs plane by plane: the shared multiplier pair handles one axis per cycle
// and a final step folds the last axis into the max/min corner sums.
// A test may stop early when a plane already rejects it.
// Reset clears control state only; planes are undefined until loaded.
// item_stall is high while a test runs; a stalled result holds in the output
// register while the next item is taken.
`default_nettype none

module frustum_cull_sphere_box #(
    parameter int NUM_PLANES  = fcsb_pkg::NUM_PLANES_DEF,
    parameter int COORD_WIDTH = fcsb_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire logic        [1:0]                op,
    input  wire logic        [3:0]                plane_index,
    input  wire logic signed [fcsb_pkg::FIELD_W-1:0] first_x,
    input  wire logic signed [fcsb_pkg::FIELD_W-1:0] first_y,
    input  wire logic signed [fcsb_pkg::FIELD_W-1:0] first_z,
    input  wire logic signed [fcsb_pkg::FIELD_W-1:0] second_x,
    input  wire logic signed [fcsb_pkg::FIELD_W-1:0] second_y,
    input  wire logic signed [fcsb_pkg::FIELD_W-1:0] second_z,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic             [1:0]                verdict
);

    localparam int CW = (COORD_WIDTH < fcsb_pkg::FIELD_W) ? COORD_WIDTH : fcsb_pkg::FIELD_W;
    localparam int IW = fcsb_pkg::idx_w(NUM_PLANES);
    localparam logic [1:0] STEP_LAST = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      step_reg, step_next;
    logic [IW-1:0]   plane_reg, plane_next;
    logic            is_box_reg, is_box_next;
    logic            all_in_reg, all_in_next;
    logic [1:0]      pend_reg, pend_next;
    logic            result_valid_reg, result_valid_next;
    logic [1:0]      verdict_reg, verdict_next;

    logic signed [CW-1:0] a_x_reg, a_y_reg, a_z_reg;
    logic signed [CW-1:0] b_x_reg, b_y_reg, b_z_reg;
    logic signed [CW-1:0] extra_reg;

    logic                 accept;
    logic                 is_test;
    logic                 is_box_in;
    logic                 last_plane;
    logic                 emit_go;
    logic                 mem_wr_en;
    logic                 mem_rd_en;
    logic [IW-1:0]        mem_rd_addr;
    logic [4*CW-1:0]      row;
    fcsb_pkg::fcsb_ctl_t  ctl;
    fcsb_pkg::fcsb_sts_t  sts;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign is_box_in  = (op == fcsb_pkg::OP_BOX);
    assign is_test    = (op == fcsb_pkg::OP_SPHERE) || is_box_in;
    assign last_plane = (plane_reg == IW'(NUM_PLANES - 1));
    assign emit_go    = (state_reg == ST_EMIT) && (!result_valid_reg || !result_stall);

    assign mem_wr_en = accept && (op == fcsb_pkg::OP_LOAD)
                       && ({1'b0, plane_index} < 5'(NUM_PLANES));

    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        if (accept && is_test)
        begin
            mem_rd_en = 1'b1;
        end
        else if ((state_reg == ST_RUN) && (step_reg == STEP_LAST) && !last_plane)
        begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = plane_reg + IW'(1);
        end
    end

    fcsb_plane_mem #(
        .NUM_PLANES (NUM_PLANES),
        .CW         (CW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (plane_index[IW-1:0]),
        .wr_data ({second_x[CW-1:0], first_z[CW-1:0], first_y[CW-1:0], first_x[CW-1:0]}),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (row)
    );

    assign ctl.init  = (state_reg == ST_RUN) && (step_reg == 2'd0);
    assign ctl.accum = (state_reg == ST_RUN) && (step_reg != 2'd0);
    assign ctl.axis  = step_reg;

    fcsb_dot_unit #(
        .CW (CW)
    ) u_dot (
        .clk   (clk),
        .ctl   (ctl),
        .row   (row),
        .a_x   (a_x_reg),
        .a_y   (a_y_reg),
        .a_z   (a_z_reg),
        .b_x   (b_x_reg),
        .b_y   (b_y_reg),
        .b_z   (b_z_reg),
        .extra (extra_reg),
        .sts   (sts)
    );

    // Capture operands; a sphere uses its center on both multipliers.
    always_ff @(posedge clk)
    begin
        if (accept && is_test)
        begin
            a_x_reg   <= first_x[CW-1:0];
            a_y_reg   <= first_y[CW-1:0];
            a_z_reg   <= first_z[CW-1:0];
            b_x_reg   <= is_box_in ? second_x[CW-1:0] : first_x[CW-1:0];
            b_y_reg   <= is_box_in ? second_y[CW-1:0] : first_y[CW-1:0];
            b_z_reg   <= is_box_in ? second_z[CW-1:0] : first_z[CW-1:0];
            extra_reg <= is_box_in ? '0 : second_x[CW-1:0];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        plane_next        = plane_reg;
        is_box_next       = is_box_reg;
        all_in_next       = all_in_reg;
        pend_next         = pend_reg;
        verdict_next      = verdict_reg;
        result_valid_next = result_valid_reg && result_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_test)
                begin
                    state_next  = ST_RUN;
                    step_next   = 2'd0;
                    plane_next  = '0;
                    is_box_next = is_box_in;
                    all_in_next = 1'b1;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == STEP_LAST)
                begin
                    if (sts.hi_neg)
                    begin
                        pend_next  = fcsb_pkg::VERDICT_OUTSIDE;
                        state_next = ST_EMIT;
                    end
                    else if (last_plane)
                    begin
                        if (!is_box_reg)
                        begin
                            pend_next = fcsb_pkg::VERDICT_VISIBLE;
                        end
                        else if (all_in_reg && !sts.lo_neg)
                        begin
                            pend_next = fcsb_pkg::VERDICT_INSIDE;
                        end
                        else
                        begin
                            pend_next = fcsb_pkg::VERDICT_INTERSECT;
                        end
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        all_in_next = all_in_reg && !sts.lo_neg;
                        plane_next  = plane_reg + IW'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    result_valid_next = 1'b1;
                    verdict_next      = pend_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= 2'd0;
            plane_reg        <= '0;
            is_box_reg       <= 1'b0;
            all_in_reg       <= 1'b1;
            pend_reg         <= fcsb_pkg::VERDICT_OUTSIDE;
            result_valid_reg <= 1'b0;
            verdict_reg      <= fcsb_pkg::VERDICT_OUTSIDE;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            plane_reg        <= plane_next;
            is_box_reg       <= is_box_next;
            all_in_reg       <= all_in_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
            verdict_reg      <= verdict_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign verdict      = verdict_reg;

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside of emit");

    a_emit_completes: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (result_valid_reg && (state_reg == ST_IDLE)))
        else $error("emit did not load the output register");

    a_test_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_test) |=> ((state_reg == ST_RUN) && (step_reg == 2'd0)
                                 && (plane_reg == '0)))
        else $error("test did not start at plane zero");

    a_plane_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (plane_reg <= IW'(NUM_PLANES - 1)))
        else $error("plane counter out of range");

endmodule

`default_nettype wire
